// ===== src/ilist_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the indexed list block: field widths, request
// codes and status codes. No dependencies.
package ilist_pkg;

  localparam int unsigned DefCapacity = 1024;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FN_READ     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INS_AT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] VAL_MISS = {VAL_W{1'b1}};

endpackage

// ===== src/ilist_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ilist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/indexed_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values held in one RAM with an
// element count; handles one request at a time. A read goes through S_RD to
// S_FIN, an append or a rejected request goes straight to S_FIN, an insert at
// position p moves the entries from the tail down to p up by one and then
// writes the new value, and a delete at p moves the entries past p down by one.
// Entries move one per cycle through the RAM's single read and single write
// port. The entries need no clearing after reset.
// Depends on ilist_pkg and ilist_ram.
module indexed_list_insert_delete
  import ilist_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [FUNC_W-1:0]       func_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [ST_W-1:0]         status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    lo_q, lo_d;
  logic             is_ins_q, is_ins_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  logic [ST_W-1:0]  res_st_q, res_st_d;

  logic             out_valid_q;
  logic [VAL_W-1:0] out_val_q;
  logic [ST_W-1:0]  out_st_q;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic          accept, out_free, out_load;
  logic [XW-1:0] pos_x, cnt_x, ins_x;
  logic [AW-1:0] pos_a, ins_a, last_a;

  ilist_ram #(
    .Width (VAL_W),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_FIN) && out_free;

  assign pos_x  = XW'(position_i);
  assign cnt_x  = XW'(count_q);
  assign pos_a  = pos_x[AW-1:0];
  assign ins_a  = ins_x[AW-1:0];
  assign last_a = AW'(count_q - CW'(1));

  always_comb begin
    unique case (func_i)
      FN_INS_HEAD: ins_x = '0;
      FN_INS_TAIL: ins_x = cnt_x;
      default:     ins_x = pos_x;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    lo_d      = lo_q;
    is_ins_d  = is_ins_q;
    val_d     = val_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_val_d = '0;
          res_st_d  = ST_DONE;
          val_d     = item_value_i;
          state_d   = S_FIN;
          unique case (func_i)
            FN_READ: begin
              if (pos_x < cnt_x) begin
                ram_re    = 1'b1;
                ram_raddr = pos_a;
                state_d   = S_RD;
              end else begin
                res_val_d = VAL_MISS;
                res_st_d  = ST_RANGE;
              end
            end
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT: begin
              if (ins_x > cnt_x) begin
                res_st_d = ST_RANGE;
              end else if (count_q == CapCount) begin
                res_st_d = ST_FULL;
              end else if (ins_x == cnt_x) begin
                // append: nothing to move
                ram_we    = 1'b1;
                ram_waddr = ins_a;
                ram_wdata = item_value_i;
                count_d   = count_q + CW'(1);
              end else begin
                // move entries up, from the tail down to the gap
                is_ins_d  = 1'b1;
                lo_d      = ins_a;
                ptr_d     = last_a;
                ram_re    = 1'b1;
                ram_raddr = last_a;
                state_d   = S_SHIFT;
              end
            end
            FN_DELETE: begin
              if (pos_x >= cnt_x) begin
                res_st_d = ST_RANGE;
              end else if (pos_a == last_a) begin
                count_d = count_q - CW'(1);
              end else begin
                // move entries down, from just past the hole to the tail
                is_ins_d  = 1'b0;
                ptr_d     = pos_a + AW'(1);
                ram_re    = 1'b1;
                ram_raddr = pos_a + AW'(1);
                state_d   = S_SHIFT;
              end
            end
            default: begin
              res_st_d = ST_RANGE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // ram_rdata holds the entry at ptr_q
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (is_ins_q) begin
          ram_waddr = ptr_q + AW'(1);
          if (ptr_q == lo_q) begin
            state_d = S_PUT;
          end else begin
            ptr_d     = ptr_q - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = ptr_q - AW'(1);
          end
        end else begin
          ram_waddr = ptr_q - AW'(1);
          if (ptr_q == last_a) begin
            count_d = count_q - CW'(1);
            state_d = S_FIN;
          end else begin
            ptr_d     = ptr_q + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = ptr_q + AW'(1);
          end
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        state_d   = S_FIN;
      end
      S_RD: begin
        res_val_d = ram_rdata;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      is_ins_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      is_ins_q <= is_ins_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    lo_q      <= lo_d;
    val_q     <= val_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("element count above capacity");

  a_write_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= count_q))
    else $error("store write beyond list tail");

  a_ptr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (CW'(ptr_q) < count_q))
    else $error("shift pointer outside list");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result presented without finishing a request");

  a_count_stable_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |=> $stable(count_q))
    else $error("count changed by a read");

endmodule

// ===== test/tb_indexed_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_insert_delete: a queue-fed driver, a shadow
// list that predicts every result, and a monitor that checks results in order.
// Depends on ilist_pkg and the block under test.
module tb_indexed_list_insert_delete;
  import ilist_pkg::*;

  localparam int unsigned ListCap   = DefCapacity;
  localparam int unsigned PosMax    = (1 << POS_W) - 1;
  localparam int unsigned QuietMax  = 12000;  // cycles with no request or result moving
  localparam int unsigned PhaseLen  = 64;     // requests per pacing phase

  typedef struct {
    logic [FUNC_W-1:0]       fn;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } list_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
  } list_rsp_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [FUNC_W-1:0]       func_i       = '0;
  logic [POS_W-1:0]        position_i   = '0;
  logic signed [VAL_W-1:0] item_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic signed [VAL_W-1:0] read_value_o;
  logic [ST_W-1:0]         status_o;

  indexed_list_insert_delete #(
    .CAPACITY(ListCap)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .status_o    (status_o)
  );

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];

  // shadow copy of the list contents
  logic signed [VAL_W-1:0] shadow_list [ListCap];
  int unsigned shadow_count = 0;

  int unsigned plan_count = 0;  // element count as seen by the stimulus generator
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_errors   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned pace_phase;

  // 0: no idling, 1: sender idle, 2: receiver stalling, 3: both lightly
  assign pace_phase = (n_accepted / PhaseLen) % 4;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Update the shadow list with one accepted request and return its result.
  task automatic apply_request(input list_req_t r, output list_rsp_t rsp);
    int unsigned p;
    int unsigned i;
    rsp.read_value = '0;
    rsp.status     = ST_DONE;
    case (r.fn)
      FN_READ: begin
        if (r.pos < shadow_count) begin
          rsp.read_value = shadow_list[r.pos];
        end else begin
          rsp.read_value = VAL_MISS;
          rsp.status     = ST_RANGE;
        end
      end
      FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT: begin
        if (r.fn == FN_INS_HEAD) p = 0;
        else if (r.fn == FN_INS_TAIL) p = shadow_count;
        else p = r.pos;
        // range check wins over the full check
        if (p > shadow_count) begin
          rsp.status = ST_RANGE;
        end else if (shadow_count >= ListCap) begin
          rsp.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = r.val;
          shadow_count++;
        end
      end
      FN_DELETE: begin
        if (r.pos >= shadow_count) begin
          rsp.status = ST_RANGE;
        end else begin
          for (i = r.pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      default: rsp.status = ST_RANGE;
    endcase
  endtask

  // Queue one request and track the element count it leaves behind.
  task automatic add_req(input logic [FUNC_W-1:0] fn, input int unsigned p,
                         input logic signed [VAL_W-1:0] v);
    list_req_t r;
    int unsigned at;
    r.fn  = fn;
    r.pos = POS_W'(p);
    r.val = v;
    pending_reqs.push_back(r);
    if (fn == FN_INS_HEAD || fn == FN_INS_TAIL || fn == FN_INS_AT) begin
      if (fn == FN_INS_HEAD) at = 0;
      else if (fn == FN_INS_TAIL) at = plan_count;
      else at = r.pos;
      if (at <= plan_count && plan_count < ListCap) plan_count++;
    end else if (fn == FN_DELETE && r.pos < plan_count) begin
      plan_count--;
    end
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(15))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return VAL_MISS;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // unknown request codes beyond the named ones
  function automatic logic [FUNC_W-1:0] FN_CODE(input int unsigned code);
    return FUNC_W'(code);
  endfunction

  // Driver: holds a request until accepted, idles at random per phase.
  always @(posedge clk_i) begin
    bit        take;
    bit        idle;
    list_rsp_t rsp;
    take = rst_ni && in_valid_i && !in_stall_o;
    if (take) begin
      apply_request(pending_reqs[0], rsp);
      expected_rsps.push_back(rsp);
      void'(pending_reqs.pop_front());
      n_accepted++;
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !take)) begin
      idle = $urandom_range(99) < ((pace_phase == 1) ? 88 : (pace_phase == 3) ? 13 : 0);
      if (pending_reqs.size() != 0 && !idle) begin
        in_valid_i   <= 1'b1;
        func_i       <= pending_reqs[0].fn;
        position_i   <= pending_reqs[0].pos;
        item_value_i <= pending_reqs[0].val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request pending", n_results));
      end else begin
        want = expected_rsps.pop_front();
        if (read_value_o !== want.read_value)
          report_mismatch($sformatf("result %0d: read_value %0d, expected %0d",
                                    n_results, read_value_o, want.read_value));
        if (status_o !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    n_results, status_o, want.status));
      end
      n_results++;
    end
    out_stall_i <= rst_ni &&
        ($urandom_range(99) < ((pace_phase == 2) ? 88 : (pace_phase == 3) ? 13 : 0));
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietMax) @(posedge clk_i);
    $display("indexed_list_insert_delete test failed");
    $finish;
  end

  initial begin
    int unsigned k;
    int unsigned sel;
    int unsigned p;

    // directed: empty list, extremes, every operation
    add_req(FN_READ, 0, '0);
    add_req(FN_DELETE, 0, '0);
    add_req(FN_INS_AT, 1, 32'sd5);
    add_req(FN_INS_AT, 0, {1'b1, {(VAL_W-1){1'b0}}});
    add_req(FN_INS_HEAD, 0, {1'b0, {(VAL_W-1){1'b1}}});
    add_req(FN_INS_TAIL, PosMax, VAL_MISS);
    add_req(FN_INS_AT, 3, '0);               // index equal to count appends
    add_req(FN_INS_AT, 1, 32'h5a5a_5a5a);
    for (k = 0; k < 5; k++) add_req(FN_READ, k, $urandom());
    add_req(FN_READ, 5, '0);
    add_req(FN_READ, PosMax, '0);
    add_req(FN_READ, 1024, '0);
    add_req(FN_DELETE, 4, '0);
    add_req(FN_DELETE, 0, '0);
    add_req(FN_DELETE, PosMax, '0);
    add_req(FN_INS_AT, PosMax, 32'sd9);
    for (k = 5; k < 8; k++) add_req(FN_CODE(k), PosMax, $urandom());
    add_req(FN_READ, 1, '0);

    // random mix on a short list
    for (k = 0; k < 520; k++) begin
      sel = $urandom_range(99);
      if (plan_count > 40 && sel >= 28 && sel < 66 && $urandom_range(1)) sel = 70;
      if (sel < 28) begin
        if (plan_count != 0 && $urandom_range(9) != 0) p = $urandom_range(plan_count - 1);
        else if ($urandom_range(1)) p = plan_count + $urandom_range(2);
        else p = $urandom_range(PosMax);
        add_req(FN_READ, p, $urandom());
      end else if (sel < 40) begin
        add_req(FN_INS_HEAD, $urandom_range(PosMax), rand_value());
      end else if (sel < 52) begin
        add_req(FN_INS_TAIL, $urandom_range(PosMax), rand_value());
      end else if (sel < 66) begin
        if ($urandom_range(7) != 0) p = $urandom_range(plan_count);
        else if ($urandom_range(1)) p = plan_count + 1 + $urandom_range(3);
        else p = $urandom_range(PosMax);
        add_req(FN_INS_AT, p, rand_value());
      end else if (sel < 92) begin
        if (plan_count != 0 && $urandom_range(7) != 0) p = $urandom_range(plan_count - 1);
        else p = $urandom_range(PosMax);
        add_req(FN_DELETE, p, $urandom());
      end else begin
        add_req(FN_CODE($urandom_range(7, 5)), $urandom_range(PosMax), $urandom());
      end
    end

    // whole-list shifts and the edges of the current list
    add_req(FN_INS_AT, plan_count + 1, rand_value());  // past the count
    add_req(FN_INS_AT, plan_count, rand_value());      // index equal to count appends
    add_req(FN_DELETE, 0, '0);                         // longest shift down
    add_req(FN_INS_HEAD, 0, rand_value());             // longest shift up
    add_req(FN_READ, 0, '0);
    add_req(FN_READ, plan_count - 1, '0);
    add_req(FN_READ, plan_count, '0);
    add_req(FN_DELETE, plan_count, '0);
    add_req(FN_DELETE, plan_count - 1, '0);
    add_req(FN_INS_TAIL, 0, rand_value());
    for (k = 0; k < 24; k++) begin
      if ($urandom_range(1)) add_req(FN_DELETE, plan_count - 1 - $urandom_range(7), '0);
      else add_req(FN_READ, plan_count - 1 - $urandom_range(15), '0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (expected_rsps.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

    if (n_errors == 0) begin
      $display("indexed_list_insert_delete test passed");
    end else begin
      $display("indexed_list_insert_delete test failed");
    end
    $finish;
  end

endmodule
